@@ rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int ARENA_BYTES  = 65536;
	localparam int HEADER_BYTES = 40;
	localparam int MAX_SEGMENTS = 256;
	localparam int ALIGN_BYTES  = 8;

	localparam int IDX_W  = 8;   // segment table index
	localparam int CNT_W  = 9;   // segment count, holds MAX_SEGMENTS
	localparam int ADDR_W = 16;
	localparam int SIZE_W = 17;

	// response status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_NO_FIT    = 2'd2;
	localparam logic [1:0] ST_BAD_FREE  = 2'd3;

	// operation codes
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	// one segment table entry
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] bytes;
		logic              busy;
	} seg_entry_t;

endpackage

@@ rtl/ffa_req_if.sv @@
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: allocate or free transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [16:0] req_size;
	logic [15:0] free_addr;

	modport source (output valid, func, req_size, free_addr, input ready);
	modport sink   (input valid, func, req_size, free_addr, output ready);
endinterface

@@ rtl/ffa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: status and granted payload offset, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] grant_addr;

	modport source (output valid, status, grant_addr, input ready);
	modport sink   (input valid, status, grant_addr, output ready);
endinterface

@@ rtl/first_fit_split_coalesce_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_split_coalesce_allocator
// First-fit allocator over one arena kept as an address-ordered segment table.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time; ready stays low until its
// response has been handed over. The segment table is a simple dual-port
// memory (one read, one write per cycle) walked by a small sequencer that
// reads and then checks each table entry visited: an allocate scans up to
// the first fit, then moves entries up when a split inserts a new segment;
// a free scans up to the match, reads its lower and upper neighbors and
// writes the merged entry, then moves entries down when segments are merged.
// No clearing pass is needed after reset.
module first_fit_split_coalesce_allocator (
	input logic      clk,
	input logic      arst_n,
	ffa_req_if.sink  req,
	ffa_rsp_if.source rsp
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SC_RD = 4'd1;
	localparam logic [3:0] S_SC_CK = 4'd2;
	localparam logic [3:0] S_IS_RD = 4'd3;
	localparam logic [3:0] S_IS_WR = 4'd4;
	localparam logic [3:0] S_IS_HI = 4'd5;
	localparam logic [3:0] S_IS_LO = 4'd6;
	localparam logic [3:0] S_FL_RD = 4'd7;
	localparam logic [3:0] S_FL_CK = 4'd8;
	localparam logic [3:0] S_FU_RD = 4'd9;
	localparam logic [3:0] S_FU_CK = 4'd10;
	localparam logic [3:0] S_FMRG  = 4'd11;
	localparam logic [3:0] S_DR_RD = 4'd12;
	localparam logic [3:0] S_DR_WR = 4'd13;

	localparam int CW = ffa_pkg::CNT_W;
	localparam int SW = ffa_pkg::SIZE_W;
	localparam int AW = ffa_pkg::ADDR_W;
	localparam logic [SW:0] HDR = (SW+1)'(ffa_pkg::HEADER_BYTES);
	localparam logic [SW:0] OVERSIZE = (SW+1)'(ffa_pkg::ARENA_BYTES + ffa_pkg::HEADER_BYTES);
	localparam logic [CW-1:0] MAXSEG = CW'(ffa_pkg::MAX_SEGMENTS);
	localparam logic [SW:0] ALIGN_M = (SW+1)'(ffa_pkg::ALIGN_BYTES - 1);
	localparam ffa_pkg::seg_entry_t RESET_ENTRY = '{
		start: '0,
		bytes: SW'(ffa_pkg::ARENA_BYTES - ffa_pkg::HEADER_BYTES),
		busy:  1'b0
	};

	// control state
	logic [3:0]    state_q;
	logic [CW-1:0] total_q;
	logic          init0_q;
	logic          out_valid_q;
	// working registers
	logic          func_q;
	logic [SW-1:0] size_q;
	logic [AW-1:0] addr_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] fi_q;
	logic [CW-1:0] k_q;
	logic [1:0]    gap_q;
	ffa_pkg::seg_entry_t cur_q;
	logic          split_q;
	logic [SW-1:0] rest_q;
	logic [AW-1:0] at_q;
	logic [SW-1:0] lo_bytes_q;
	logic [SW-1:0] acc_q;
	logic          lfree_q;
	logic          ufree_q;
	logic [AW-1:0] lo_start_q;
	logic [1:0]    status_q;
	logic [AW-1:0] grant_q;

	// segment table
	ffa_pkg::seg_entry_t mem [ffa_pkg::MAX_SEGMENTS];
	ffa_pkg::seg_entry_t rdata_q;
	logic                rd0_q;
	logic                re, we;
	logic [ffa_pkg::IDX_W-1:0] raddr, waddr;
	ffa_pkg::seg_entry_t wdata;
	ffa_pkg::seg_entry_t rent;

	// sequencer outputs
	logic          fin;
	logic [1:0]    fin_status;
	logic [AW-1:0] fin_grant;
	logic [3:0]    state_d;

	// scan compare helpers
	logic [SW:0]   rounded;
	logic [SW:0]   need;
	logic          alloc_hit, free_hit, split_ok;
	logic [AW-1:0] pay_off;

	assign req.ready      = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.grant_addr = grant_q;

	// table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// entry 0 reads as its reset value until it is first written
	assign rent = (rd0_q && init0_q) ? RESET_ENTRY : rdata_q;

	assign rounded   = ({1'b0, size_q} + ALIGN_M) & ~ALIGN_M;
	assign need      = rounded + HDR;
	assign pay_off   = AW'({1'b0, rent.start} + HDR);
	assign alloc_hit = !rent.busy && (rent.bytes >= size_q);
	assign free_hit  = (pay_off == addr_q);
	assign split_ok  = (total_q < MAXSEG) && ({1'b0, rent.bytes} >= need);

	// sequencer
	always_comb begin
		state_d    = state_q;
		re         = 1'b0;
		we         = 1'b0;
		raddr      = '0;
		waddr      = '0;
		wdata      = rent;
		fin        = 1'b0;
		fin_status = ffa_pkg::ST_OK;
		fin_grant  = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					if (req.func == ffa_pkg::FN_ALLOC && {1'b0, req.req_size} >= OVERSIZE) begin
						fin        = 1'b1;
						fin_status = ffa_pkg::ST_TOO_LARGE;
					end else begin
						state_d = S_SC_RD;
					end
				end
			end
			S_SC_RD: begin
				if (idx_q >= total_q) begin
					fin        = 1'b1;
					fin_status = (func_q == ffa_pkg::FN_ALLOC) ? ffa_pkg::ST_NO_FIT
						: ffa_pkg::ST_BAD_FREE;
					state_d    = S_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = idx_q[ffa_pkg::IDX_W-1:0];
					state_d = S_SC_CK;
				end
			end
			S_SC_CK: begin
				if (func_q == ffa_pkg::FN_ALLOC && alloc_hit) begin
					state_d = split_ok ? S_IS_RD : S_IS_LO;
				end else if (func_q == ffa_pkg::FN_FREE && free_hit) begin
					state_d = S_FL_RD;
				end else begin
					state_d = S_SC_RD;
				end
			end
			// move entries up to open a slot above the split segment
			S_IS_RD: begin
				if (k_q > fi_q + CW'(1)) begin
					re      = 1'b1;
					raddr   = ffa_pkg::IDX_W'(k_q - CW'(1));
					state_d = S_IS_WR;
				end else begin
					state_d = S_IS_HI;
				end
			end
			S_IS_WR: begin
				we      = 1'b1;
				waddr   = k_q[ffa_pkg::IDX_W-1:0];
				wdata   = rent;
				state_d = S_IS_RD;
			end
			S_IS_HI: begin
				we      = 1'b1;
				waddr   = ffa_pkg::IDX_W'(fi_q + CW'(1));
				wdata   = '{start: at_q, bytes: rest_q, busy: 1'b0};
				state_d = S_IS_LO;
			end
			S_IS_LO: begin
				we         = 1'b1;
				waddr      = fi_q[ffa_pkg::IDX_W-1:0];
				wdata      = '{start: cur_q.start, bytes: lo_bytes_q, busy: 1'b1};
				fin        = 1'b1;
				fin_grant  = AW'({1'b0, cur_q.start} + HDR);
				state_d    = S_IDLE;
			end
			// look at the lower and upper neighbors of the freed segment
			S_FL_RD: begin
				if (fi_q == '0) begin
					state_d = S_FU_RD;
				end else begin
					re      = 1'b1;
					raddr   = ffa_pkg::IDX_W'(fi_q - CW'(1));
					state_d = S_FL_CK;
				end
			end
			S_FL_CK: begin
				state_d = S_FU_RD;
			end
			S_FU_RD: begin
				if (fi_q + CW'(1) >= total_q) begin
					state_d = S_FMRG;
				end else begin
					re      = 1'b1;
					raddr   = ffa_pkg::IDX_W'(fi_q + CW'(1));
					state_d = S_FU_CK;
				end
			end
			S_FU_CK: begin
				state_d = S_FMRG;
			end
			S_FMRG: begin
				we    = 1'b1;
				waddr = lfree_q ? ffa_pkg::IDX_W'(fi_q - CW'(1)) : fi_q[ffa_pkg::IDX_W-1:0];
				wdata = '{start: lfree_q ? lo_start_q : cur_q.start, bytes: acc_q, busy: 1'b0};
				if (!lfree_q && !ufree_q) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DR_RD;
				end
			end
			// close the gap left by merged segments
			S_DR_RD: begin
				if (k_q + CW'(gap_q) < total_q) begin
					re      = 1'b1;
					raddr   = ffa_pkg::IDX_W'(k_q + CW'(gap_q));
					state_d = S_DR_WR;
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DR_WR: begin
				we      = 1'b1;
				waddr   = k_q[ffa_pkg::IDX_W-1:0];
				wdata   = rent;
				state_d = S_DR_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= CW'(1);
			init0_q     <= 1'b1;
			out_valid_q <= 1'b0;
			rd0_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (re) begin
				rd0_q <= (raddr == '0);
			end
			if (we && waddr == '0) begin
				init0_q <= 1'b0;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IS_HI) begin
				total_q <= total_q + CW'(1);
			end else if (state_q == S_DR_RD && state_d == S_IDLE) begin
				total_q <= total_q - CW'(gap_q);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (fin) begin
			status_q <= fin_status;
			grant_q  <= fin_grant;
		end
		case (state_q)
			S_IDLE: begin
				func_q <= req.func;
				size_q <= req.req_size;
				addr_q <= req.free_addr;
				idx_q  <= '0;
			end
			S_SC_CK: begin
				idx_q      <= idx_q + CW'(1);
				fi_q       <= idx_q;
				cur_q      <= rent;
				split_q    <= split_ok;
				rest_q     <= SW'({1'b0, rent.bytes} - need);
				at_q       <= AW'({1'b0, rent.start} + HDR + rounded);
				lo_bytes_q <= split_ok ? SW'(rounded) : rent.bytes;
				k_q        <= total_q;
				acc_q      <= rent.bytes;
				lfree_q    <= 1'b0;
				ufree_q    <= 1'b0;
			end
			S_IS_WR: begin
				k_q <= k_q - CW'(1);
			end
			S_FL_CK: begin
				if (!rent.busy) begin
					lfree_q    <= 1'b1;
					lo_start_q <= rent.start;
					acc_q      <= SW'({1'b0, acc_q} + {1'b0, rent.bytes} + HDR);
				end
			end
			S_FU_CK: begin
				if (!rent.busy) begin
					ufree_q <= 1'b1;
					acc_q   <= SW'({1'b0, acc_q} + {1'b0, rent.bytes} + HDR);
				end
			end
			S_FMRG: begin
				gap_q <= {1'b0, lfree_q} + {1'b0, ufree_q};
				k_q   <= lfree_q ? fi_q : fi_q + CW'(1);
			end
			S_DR_WR: begin
				k_q <= k_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	// checks
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != '0) && (total_q <= MAXSEG))
		else $error("segment count out of range");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ffa_pkg::ST_OK) |-> (grant_q == '0))
		else $error("grant offset on failed transaction");

	a_split_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IS_HI) |=> (total_q == $past(total_q) + CW'(1)))
		else $error("split did not add a segment");

	a_split_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IS_HI) |-> split_q && (total_q < MAXSEG))
		else $error("split with full table");

endmodule
